>>> design/pmd_pkg.sv
// Shared types and constants of the pairwise Minkowski distance block.
package pmd_pkg;

  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned ROW_IN_W  = 8;
  localparam int unsigned FEAT_IN_W = 6;
  localparam int unsigned DIST_W    = 18;
  localparam int unsigned ACC_W     = 64;
  localparam int unsigned BIT_W     = $clog2(DIST_W);
  localparam int unsigned FCOUNT_W  = 7;
  localparam int unsigned NPOW_W    = 3;
  localparam int unsigned TDATA_W   = 40;
  localparam int unsigned CFG_AW    = 3;
  localparam int unsigned CFG_DW    = 32;

  localparam logic [FCOUNT_W-1:0] FCOUNT_RST = 7'd64;
  localparam logic [NPOW_W-1:0]   NPOW_RST   = 3'd2;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic REG_FCOUNT = 1'b0;
  localparam logic REG_NPOW   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_POW,
    ST_ACCUM,
    ST_ROOT_INIT,
    ST_ROOT_POW,
    ST_ROOT_CMP,
    ST_DONE
  } pmd_state_e;

endpackage

>>> design/pmd_ram.sv
// Generic RAM: one write port, two registered read ports.
module pmd_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> design/pmd_sat_mul.sv
// Shared saturating multiplier: 64-bit running product times 18-bit operand.
module pmd_sat_mul
  import pmd_pkg::*;
(
  input  logic [ACC_W-1:0]  acc_i,
  input  logic [DIST_W-1:0] opnd_i,
  output logic [ACC_W-1:0]  prod_o
);

  logic [ACC_W+DIST_W-1:0] full;

  assign full   = (ACC_W+DIST_W)'(acc_i) * (ACC_W+DIST_W)'(opnd_i);
  assign prod_o = (|full[ACC_W+DIST_W-1:ACC_W]) ? '1 : full[ACC_W-1:0];

endmodule

>>> design/pairwise_minkowski_distance.sv
// Top level of the pairwise Minkowski distance block.
//
//  port group  | direction | word                                          | accepted when
//  s_axis_*    | in        | tuser: func; tdata: row_a,row_b,feature,value | tvalid & tready
//  m_axis_*    | out       | tdata: distance, pair_first, pair_second      | tvalid & tready
//  APB         | in        | feature_count @0x0, norm_power @0x4           | psel&penable&pwrite
//
//  Write words stream back to back.
//  A query reads each of nf features, raises |a-b| to exponent p and sums it, then
//  finds the root bit by bit over 18 bits, all with the one shared saturating
//  multiplier: p passes per feature and per root bit. s_axis_tready is low while a query runs.
//  A finished distance waits in the output register; a next query may start meanwhile.
//  Reset clears control state and loads feature_count 64, norm_power 2; the
//  sample store is not cleared.
module pairwise_minkowski_distance
  import pmd_pkg::*;
#(
  parameter int unsigned MAX_ROWS     = 256,
  parameter int unsigned MAX_FEATURES = 64,
  parameter int unsigned MAX_POWER    = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic                s_axis_tuser,   // func
  input  logic [TDATA_W-1:0]  s_axis_tdata,   // row_a, row_b, feature, value, zero pad
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [TDATA_W-1:0]  m_axis_tdata,   // distance, pair_first, pair_second, zero pad
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [CFG_DW-1:0]   pwdata,
  output logic [CFG_DW-1:0]   prdata,
  output logic                pready
);

  localparam int unsigned DEPTH  = MAX_ROWS * MAX_FEATURES;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(MAX_FEATURES + 1);
  localparam int unsigned P_W    = $clog2(MAX_POWER + 1);

  pmd_state_e state_q, state_d;

  logic [FCOUNT_W-1:0] fcount_q;
  logic [NPOW_W-1:0]   npow_q;

  logic [ROW_IN_W-1:0]  in_row_a, in_row_b;
  logic [FEAT_IN_W-1:0] in_feat;
  logic [SAMPLE_W-1:0]  in_value;
  logic                 in_acc;

  logic [ROW_IN_W-1:0] row_a_q, row_a_d, row_b_q, row_b_d;
  logic [ADDR_W-1:0]   base_a_q, base_a_d, base_b_q, base_b_d;
  logic                oob_a_q, oob_a_d, oob_b_q, oob_b_d;
  logic [CNT_W-1:0]    feat_q, feat_d;
  logic [P_W-1:0]      cnt_q, cnt_d;
  logic [ACC_W-1:0]    acc_q, acc_d, sum_q, sum_d;
  logic [DIST_W-1:0]   opnd_q, opnd_d, root_q, root_d;
  logic [BIT_W-1:0]    bit_q, bit_d;

  logic                m_valid_q, m_valid_d;
  logic [DIST_W-1:0]   m_dist_q, m_dist_d;
  logic [ROW_IN_W-1:0] m_first_q, m_first_d, m_second_q, m_second_d;

  logic [CNT_W-1:0] nf_eff;
  logic [P_W-1:0]   p_eff;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [SAMPLE_W-1:0] rdata_a, rdata_b;
  logic [SAMPLE_W-1:0] samp_a, samp_b;
  logic [SAMPLE_W:0]   diff, diff_abs;
  logic [ACC_W-1:0]    prod;
  logic [ACC_W:0]      sum_ext;
  logic                cfg_we;

  assign in_row_a = s_axis_tdata[7:0];
  assign in_row_b = s_axis_tdata[15:8];
  assign in_feat  = s_axis_tdata[21:16];
  assign in_value = s_axis_tdata[33:22];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_NPOW) ? CFG_DW'(npow_q) : CFG_DW'(fcount_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcount_q <= FCOUNT_RST;
      npow_q   <= NPOW_RST;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_FCOUNT: fcount_q <= pwdata[FCOUNT_W-1:0];
        REG_NPOW:   npow_q   <= pwdata[NPOW_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    if (fcount_q == '0) begin
      nf_eff = CNT_W'(1);
    end else if (32'(fcount_q) > MAX_FEATURES) begin
      nf_eff = CNT_W'(MAX_FEATURES);
    end else begin
      nf_eff = CNT_W'(fcount_q);
    end
    if (npow_q == '0) begin
      p_eff = P_W'(1);
    end else if (32'(npow_q) > MAX_POWER) begin
      p_eff = P_W'(MAX_POWER);
    end else begin
      p_eff = P_W'(npow_q);
    end
  end

  // sample store
  assign ram_we = in_acc && (s_axis_tuser == FUNC_WRITE) &&
                  (32'(in_row_a) < MAX_ROWS) && (32'(in_feat) < MAX_FEATURES);
  assign ram_waddr = ADDR_W'(32'(in_row_a) * MAX_FEATURES + 32'(in_feat));

  pmd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (in_value),
    .raddr_a_i (base_a_q + ADDR_W'(feat_q)),
    .raddr_b_i (base_b_q + ADDR_W'(feat_q)),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  assign samp_a   = oob_a_q ? '0 : rdata_a;
  assign samp_b   = oob_b_q ? '0 : rdata_b;
  assign diff     = {samp_a[SAMPLE_W-1], samp_a} - {samp_b[SAMPLE_W-1], samp_b};
  assign diff_abs = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;

  pmd_sat_mul u_mul (
    .acc_i  (acc_q),
    .opnd_i (opnd_q),
    .prod_o (prod)
  );

  assign sum_ext = {1'b0, sum_q} + {1'b0, acc_q};

  always_comb begin
    state_d    = state_q;
    row_a_d    = row_a_q;
    row_b_d    = row_b_q;
    base_a_d   = base_a_q;
    base_b_d   = base_b_q;
    oob_a_d    = oob_a_q;
    oob_b_d    = oob_b_q;
    feat_d     = feat_q;
    cnt_d      = cnt_q;
    acc_d      = acc_q;
    sum_d      = sum_q;
    opnd_d     = opnd_q;
    root_d     = root_q;
    bit_d      = bit_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_dist_d   = m_dist_q;
    m_first_d  = m_first_q;
    m_second_d = m_second_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (s_axis_tuser == FUNC_QUERY)) begin
          row_a_d  = in_row_a;
          row_b_d  = in_row_b;
          oob_a_d  = (32'(in_row_a) >= MAX_ROWS);
          oob_b_d  = (32'(in_row_b) >= MAX_ROWS);
          base_a_d = ADDR_W'(32'(in_row_a) * MAX_FEATURES);
          base_b_d = ADDR_W'(32'(in_row_b) * MAX_FEATURES);
          feat_d   = '0;
          sum_d    = '0;
          state_d  = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        opnd_d  = DIST_W'(diff_abs[SAMPLE_W-1:0]);
        acc_d   = ACC_W'(1);
        cnt_d   = p_eff;
        state_d = ST_POW;
      end
      ST_POW: begin
        acc_d = prod;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == P_W'(1)) begin
          state_d = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        sum_d = sum_ext[ACC_W] ? '1 : sum_ext[ACC_W-1:0];
        if (feat_q == nf_eff - 1'b1) begin
          root_d  = '0;
          bit_d   = BIT_W'(DIST_W - 1);
          state_d = ST_ROOT_INIT;
        end else begin
          feat_d  = feat_q + 1'b1;
          state_d = ST_READ;
        end
      end
      ST_ROOT_INIT: begin
        opnd_d  = root_q | (DIST_W'(1) << bit_q);
        acc_d   = ACC_W'(1);
        cnt_d   = p_eff;
        state_d = ST_ROOT_POW;
      end
      ST_ROOT_POW: begin
        acc_d = prod;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == P_W'(1)) begin
          state_d = ST_ROOT_CMP;
        end
      end
      ST_ROOT_CMP: begin
        if (acc_q <= sum_q) begin
          root_d = opnd_q;
        end
        if (bit_q == '0) begin
          state_d = ST_DONE;
        end else begin
          bit_d   = bit_q - 1'b1;
          state_d = ST_ROOT_INIT;
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          m_dist_d   = root_q;
          m_first_d  = row_a_q;
          m_second_d = row_b_q;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_a_q    <= row_a_d;
    row_b_q    <= row_b_d;
    base_a_q   <= base_a_d;
    base_b_q   <= base_b_d;
    oob_a_q    <= oob_a_d;
    oob_b_q    <= oob_b_d;
    feat_q     <= feat_d;
    cnt_q      <= cnt_d;
    acc_q      <= acc_d;
    sum_q      <= sum_d;
    opnd_q     <= opnd_d;
    root_q     <= root_d;
    bit_q      <= bit_d;
    m_dist_q   <= m_dist_d;
    m_first_q  <= m_first_d;
    m_second_q <= m_second_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(TDATA_W - DIST_W - 2*ROW_IN_W)'(0), m_second_q, m_first_q, m_dist_q};

endmodule

>>> design/pmd_checker.sv
// Port-level checks of the pairwise Minkowski distance block, bound to the top level.
module pmd_checker
  import pmd_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               s_axis_tuser,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata
);

  a_query_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_QUERY)) |=> !s_axis_tready)
    else $error("input still ready after a query word");

  a_write_streams: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_WRITE)) |=> s_axis_tready)
    else $error("input not ready after a write word");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output word dropped or changed");

  a_result_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[TDATA_W-1:DIST_W+2*ROW_IN_W] == '0))
    else $error("output pad bits not zero");

endmodule

bind pairwise_minkowski_distance pmd_checker u_pmd_checker (.*);
